/* rtl/issp_pkg.sv */
// Package for the int8 stream statistics profiler.
// Holds field structs, codes and widths; depends on nothing.
package issp_pkg;
  localparam int CountWidth = 40;
  localparam int BinCount = 256;
  localparam int BinAw = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_BIN = 2'd1, OP_REPORT = 2'd2, OP_CLEAR = 2'd3
  } op_t;

  localparam logic [3:0] CODE_COUNT = 4'd0;
  localparam logic [3:0] CODE_MIN = 4'd1;
  localparam logic [3:0] CODE_MAX = 4'd2;
  localparam logic [3:0] CODE_SUM = 4'd3;
  localparam logic [3:0] CODE_SUMSQ = 4'd4;
  localparam logic [3:0] CODE_ZEROS = 4'd5;
  localparam logic [3:0] CODE_DISTINCT = 4'd6;
  localparam logic [3:0] CODE_DSUM = 4'd7;
  localparam logic [3:0] CODE_MAXD = 4'd8;
  localparam logic [3:0] CODE_SMALL = 4'd9;
  localparam logic [3:0] CODE_ZDELTA = 4'd10;
  localparam logic [3:0] CODE_RUNS = 4'd11;
  localparam logic [3:0] CODE_MAXRUN = 4'd12;
  localparam logic [3:0] CODE_BIN = 4'd13;

  typedef struct packed {
    logic [1:0] operation;
    logic signed [7:0] sample;
    logic [7:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0] stat_code;
    logic signed [63:0] stat_value;
    logic last_of_run;
  } out_item_t;
endpackage

/* rtl/issp_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module issp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/issp_front.sv */
// Front end: accepts input transactions into a short queue.
// Depends on issp_pkg.
module issp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  issp_pkg::in_item_t din,
  output logic               full,
  output logic               q_valid,
  output issp_pkg::in_item_t q_item,
  input  logic               q_take
);
  issp_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic acc;
  assign full = cnt_r[1];
  assign acc = push && !full;
  assign q_valid = cnt_r != 2'd0;
  assign q_item = buf_r[rd_r];
  always_comb cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, q_take};
  always_ff @(posedge clk) begin
    if (acc) buf_r[wr_r] <= din;
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) wr_r <= !wr_r;
      if (q_take) rd_r <= !rd_r;
    end
  end
endmodule

/* rtl/issp_back.sv */
// Back end: executes queued transactions, keeps statistics and histogram.
// Depends on issp_pkg and issp_ram.
module issp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  issp_pkg::in_item_t  q_item,
  output logic                q_take,
  output logic                out_empty,
  output issp_pkg::out_item_t dout,
  input  logic                out_pop
);
  localparam int CW = issp_pkg::CountWidth;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RD = 6'b000010, S_ADD = 6'b000100,
    S_BIN = 6'b001000, S_REP = 6'b010000, S_CLR = 6'b100000
  } st_t;
  st_t st_r, st_nxt;

  issp_pkg::in_item_t cur_r;
  logic [3:0] idx_r;
  logic [issp_pkg::BinCount-1:0] valid_r;
  logic [CW-1:0] cnt_r, zeros_r, small_r, zd_r, runs_r, crun_r, lrun_r;
  logic signed [7:0] lo_r, hi_r, prev_r;
  logic signed [47:0] sum_r;
  logic [55:0] sq_r;
  logic [47:0] ds_r;
  logic [7:0] ld_r;
  logic [8:0] dist_r;
  logic havep_r;
  logic ov_r;
  issp_pkg::out_item_t o_r;

  logic we;
  logic [issp_pkg::BinAw-1:0] waddr, raddr;
  logic [CW-1:0] wdata, rdata, bin_val;
  issp_ram #(.Width(CW), .Depth(issp_pkg::BinCount)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [issp_pkg::BinAw-1:0] bsel;
  assign bsel = (cur_r.operation == issp_pkg::OP_ADD) ? cur_r.sample : cur_r.bin_index;
  assign raddr = (st_r == S_IDLE) ?
      ((q_item.operation == issp_pkg::OP_ADD) ? q_item.sample : q_item.bin_index) : bsel;
  assign bin_val = valid_r[bsel] ? rdata : '0;
  assign we = (st_r == S_ADD) && (bin_val != CMAX);
  assign waddr = bsel;
  assign wdata = bin_val + 1'b1;

  assign out_empty = !ov_r;
  assign dout = o_r;
  assign q_take = (st_r == S_IDLE) && q_valid;

  function automatic logic [CW-1:0] sinc(input logic [CW-1:0] v);
    return (v == CMAX) ? v : v + 1'b1;
  endfunction

  logic signed [8:0] dlt;
  logic [7:0] ad;
  logic signed [48:0] nsum;
  logic [56:0] nsq;
  logic [48:0] nds;
  logic [15:0] sq16;
  logic [CW-1:0] crun_n;
  logic can_out;
  logic load_out;
  assign can_out = !ov_r || out_pop;
  assign load_out = can_out && (st_r == S_BIN || st_r == S_REP);
  always_comb begin
    dlt = {cur_r.sample[7], cur_r.sample} - {prev_r[7], prev_r};
    ad = dlt[8] ? 8'(-dlt) : dlt[7:0];
    nsum = {sum_r[47], sum_r} + 49'(cur_r.sample);
    sq16 = 16'($signed(cur_r.sample) * $signed(cur_r.sample));
    nsq = {1'b0, sq_r} + {41'd0, sq16};
    nds = {1'b0, ds_r} + {41'd0, ad};
    crun_n = (havep_r && ad == 8'd0) ? sinc(crun_r) : {{(CW-1){1'b0}}, 1'b1};
  end

  logic [63:0] rv;
  always_comb begin
    case (idx_r)
      issp_pkg::CODE_COUNT: rv = 64'(cnt_r);
      issp_pkg::CODE_MIN: rv = 64'(signed'(lo_r));
      issp_pkg::CODE_MAX: rv = 64'(signed'(hi_r));
      issp_pkg::CODE_SUM: rv = 64'(signed'(sum_r));
      issp_pkg::CODE_SUMSQ: rv = 64'(sq_r);
      issp_pkg::CODE_ZEROS: rv = 64'(zeros_r);
      issp_pkg::CODE_DISTINCT: rv = 64'(dist_r);
      issp_pkg::CODE_DSUM: rv = 64'(ds_r);
      issp_pkg::CODE_MAXD: rv = 64'(ld_r);
      issp_pkg::CODE_SMALL: rv = 64'(small_r);
      issp_pkg::CODE_ZDELTA: rv = 64'(zd_r);
      issp_pkg::CODE_RUNS: rv = 64'(runs_r);
      default: rv = 64'(lrun_r);
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) begin
        case (q_item.operation)
          issp_pkg::OP_CLEAR: st_nxt = S_CLR;
          issp_pkg::OP_REPORT: st_nxt = S_REP;
          default: st_nxt = S_RD;
        endcase
      end
      S_RD: st_nxt = (cur_r.operation == issp_pkg::OP_ADD) ? S_ADD : S_BIN;
      S_ADD: st_nxt = S_IDLE;
      S_BIN: if (can_out) st_nxt = S_IDLE;
      S_REP: if (can_out && idx_r == issp_pkg::CODE_MAXRUN) st_nxt = S_IDLE;
      S_CLR: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_take) cur_r <= q_item;
    if (can_out && st_r == S_BIN) o_r <= '{issp_pkg::CODE_BIN, 64'(bin_val), 1'b1};
    if (can_out && st_r == S_REP)
      o_r <= '{idx_r, rv, idx_r == issp_pkg::CODE_MAXRUN};
    if (st_r == S_ADD) begin
      prev_r <= cur_r.sample;
    end
    if (!rst_n || st_r == S_CLR) begin
      st_r <= S_IDLE;
      // A clear keeps a waiting result but still lets it be popped.
      ov_r <= rst_n && ov_r && !out_pop;
      idx_r <= '0; valid_r <= '0;
      cnt_r <= '0; zeros_r <= '0; small_r <= '0; zd_r <= '0;
      runs_r <= '0; crun_r <= '0; lrun_r <= '0;
      lo_r <= 8'sd127; hi_r <= -8'sd128; sum_r <= '0; sq_r <= '0;
      ds_r <= '0; ld_r <= '0; dist_r <= '0; havep_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= load_out || (ov_r && !out_pop);
      if (st_r == S_REP && can_out)
        idx_r <= (idx_r == issp_pkg::CODE_MAXRUN) ? '0 : idx_r + 1'b1;
      if (st_r == S_ADD) begin
        valid_r[bsel] <= 1'b1;
        if (bin_val == '0) dist_r <= dist_r + 1'b1;
        cnt_r <= sinc(cnt_r);
        if (cur_r.sample < lo_r) lo_r <= cur_r.sample;
        if (cur_r.sample > hi_r) hi_r <= cur_r.sample;
        if (nsum > 49'sh0_7FFF_FFFF_FFFF) sum_r <= 48'sh7FFF_FFFF_FFFF;
        else if (nsum < -49'sh0_8000_0000_0000) sum_r <= 48'sh8000_0000_0000;
        else sum_r <= nsum[47:0];
        sq_r <= nsq[56] ? '1 : nsq[55:0];
        if (cur_r.sample == 8'sd0) zeros_r <= sinc(zeros_r);
        if (havep_r) begin
          ds_r <= nds[48] ? '1 : nds[47:0];
          if (ad > ld_r) ld_r <= ad;
          if (ad < 8'd2) small_r <= sinc(small_r);
          if (ad == 8'd0) zd_r <= sinc(zd_r);
          else runs_r <= sinc(runs_r);
        end else runs_r <= sinc(runs_r);
        crun_r <= crun_n;
        if (crun_n > lrun_r) lrun_r <= crun_n;
        havep_r <= 1'b1;
      end
    end
  end
endmodule

/* rtl/int8_stream_statistics_profiler_top.sv */
// Top level of the int8 stream statistics profiler.
// Depends on issp_pkg, issp_front, issp_back (and issp_ram through it).
//
// Usage:
//   Input queue: drive in_item and raise in_push; a transaction is taken at a
//   clock edge where in_push is high and in_full is low. Operations: add
//   sample, read one histogram bin, report thirteen statistics, clear.
//   Result queue: while out_empty is low, out_item holds the oldest result;
//   raise out_pop to take it. last_of_run marks the end of a report or bin
//   read.
//   Sequencing: the back end takes a transaction only in its idle state and
//   finishes it before taking the next. An add does a RAM read, then a
//   read-modify-write of the 40-bit bin; a bin read does a RAM read and
//   then loads the result; a report loads thirteen results in turn; a
//   clear resets the statistics. A two-entry front queue accepts
//   transactions while the back end works.
//   Reset: synchronous active-low rst_n empties both queues and clears all
//   statistics; histogram bins clear at once through per-bin valid flags.
//   Stall: if out_pop stays low the back end holds its result and stops at
//   its next bin read or report; the front queue then fills, raising in_full.
module int8_stream_statistics_profiler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  issp_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  output issp_pkg::out_item_t out_item,
  input  logic                out_pop
);
  logic q_valid, q_take;
  issp_pkg::in_item_t q_item;

  // Decouple acceptance from execution.
  issp_front u_front (
    .clk, .rst_n, .push(in_push), .din(in_item), .full(in_full),
    .q_valid, .q_item, .q_take
  );

  // Execute transactions and hold the result register.
  issp_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_take,
    .out_empty, .dout(out_item), .out_pop
  );
endmodule

/* bench/int8_stream_statistics_profiler_top_test.sv */
// Self-checking bench for the int8 stream statistics profiler top level.
// Depends on issp_pkg and int8_stream_statistics_profiler_top; predicts every
// statistic in the bench and compares each result transaction field by field.
module int8_stream_statistics_profiler_top_test;
  localparam logic [63:0] CntMax = (64'd1 << issp_pkg::CountWidth) - 64'd1;
  localparam logic signed [63:0] SumPosMax = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] SumNegMin = -SumPosMax - 64'sd1;
  localparam logic [63:0] SqMax = (64'd1 << 56) - 64'd1;
  localparam logic [63:0] DsumMax = (64'd1 << 48) - 64'd1;

  logic clk;
  logic rst_n;
  logic in_push;
  issp_pkg::in_item_t in_item;
  logic in_full;
  logic out_empty;
  issp_pkg::out_item_t out_item;
  logic out_pop;

  int8_stream_statistics_profiler_top dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_item(in_item),
    .in_full(in_full), .out_empty(out_empty), .out_item(out_item),
    .out_pop(out_pop)
  );

  // Predicted profiler state; counts and totals are kept in 64-bit containers.
  logic [63:0] hist_model [issp_pkg::BinCount];
  logic [63:0] n_samples, n_zeros, n_small, n_zdelta, n_runs, cur_run, best_run;
  logic [63:0] sq_total, dsum_total;
  logic signed [63:0] sum_total;
  int lo_val, hi_val, prev_val, max_delta, n_distinct;
  bit have_prev;
  bit in_taken;

  issp_pkg::in_item_t pending_items [$];
  issp_pkg::out_item_t expected_stats [$];

  int errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 67;

  function automatic logic [63:0] bump(logic [63:0] v);
    return (v < CntMax) ? v + 64'd1 : CntMax;
  endfunction

  function automatic logic [63:0] add_capped(logic [63:0] v, logic [63:0] a,
                                             logic [63:0] lim);
    return (v > lim - a) ? lim : v + a;
  endfunction

  task automatic clear_profile();
    for (int i = 0; i < issp_pkg::BinCount; i++) hist_model[i] = '0;
    n_samples = '0; n_zeros = '0; n_small = '0; n_zdelta = '0;
    n_runs = '0; cur_run = '0; best_run = '0;
    sq_total = '0; dsum_total = '0; sum_total = '0;
    lo_val = 127; hi_val = -128; prev_val = 0; max_delta = 0;
    n_distinct = 0; have_prev = 0;
  endtask

  task automatic push_stat(logic [3:0] code, logic [63:0] val, logic last);
    issp_pkg::out_item_t r;
    r.stat_code = code;
    r.stat_value = val;
    r.last_of_run = last;
    expected_stats.push_back(r);
  endtask

  // Advance the predicted state by one accepted transaction.
  task automatic profile_step(issp_pkg::in_item_t it);
    int s, ad;
    logic signed [63:0] ns;
    s = int'(it.sample);
    case (issp_pkg::op_t'(it.operation))
      issp_pkg::OP_ADD: begin
        if (hist_model[it.sample[7:0]] == 0) n_distinct++;
        hist_model[it.sample[7:0]] = bump(hist_model[it.sample[7:0]]);
        n_samples = bump(n_samples);
        if (s < lo_val) lo_val = s;
        if (s > hi_val) hi_val = s;
        ns = sum_total + s;
        if (ns > SumPosMax) ns = SumPosMax;
        if (ns < SumNegMin) ns = SumNegMin;
        sum_total = ns;
        sq_total = add_capped(sq_total, 64'(s * s), SqMax);
        if (s == 0) n_zeros = bump(n_zeros);
        if (have_prev) begin
          ad = (s > prev_val) ? s - prev_val : prev_val - s;
          dsum_total = add_capped(dsum_total, 64'(ad), DsumMax);
          if (ad > max_delta) max_delta = ad;
          if (ad < 2) n_small = bump(n_small);
          if (ad == 0) begin
            n_zdelta = bump(n_zdelta);
            cur_run = bump(cur_run);
          end else begin
            n_runs = bump(n_runs);
            cur_run = 64'd1;
          end
        end else begin
          n_runs = bump(n_runs);
          cur_run = 64'd1;
        end
        if (cur_run > best_run) best_run = cur_run;
        prev_val = s;
        have_prev = 1;
      end
      issp_pkg::OP_BIN: push_stat(issp_pkg::CODE_BIN, hist_model[it.bin_index], 1'b1);
      issp_pkg::OP_REPORT: begin
        push_stat(issp_pkg::CODE_COUNT, n_samples, 1'b0);
        push_stat(issp_pkg::CODE_MIN, 64'(signed'(lo_val)), 1'b0);
        push_stat(issp_pkg::CODE_MAX, 64'(signed'(hi_val)), 1'b0);
        push_stat(issp_pkg::CODE_SUM, sum_total, 1'b0);
        push_stat(issp_pkg::CODE_SUMSQ, sq_total, 1'b0);
        push_stat(issp_pkg::CODE_ZEROS, n_zeros, 1'b0);
        push_stat(issp_pkg::CODE_DISTINCT, 64'(n_distinct), 1'b0);
        push_stat(issp_pkg::CODE_DSUM, dsum_total, 1'b0);
        push_stat(issp_pkg::CODE_MAXD, 64'(max_delta), 1'b0);
        push_stat(issp_pkg::CODE_SMALL, n_small, 1'b0);
        push_stat(issp_pkg::CODE_ZDELTA, n_zdelta, 1'b0);
        push_stat(issp_pkg::CODE_RUNS, n_runs, 1'b0);
        push_stat(issp_pkg::CODE_MAXRUN, best_run, 1'b1);
      end
      default: clear_profile();
    endcase
  endtask

  function automatic issp_pkg::in_item_t make_item(issp_pkg::op_t op, int smp, int bidx);
    issp_pkg::in_item_t it;
    it.operation = op;
    it.sample = smp[7:0];
    it.bin_index = bidx[7:0];
    return it;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Record each input transaction at its accepting edge and advance the
  // prediction.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      profile_step(in_item);
      n_sent++;
      void'(pending_items.pop_front());
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: hold the item until it is accepted, then advance the queue.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_item <= '0;
    end else if (!in_push || in_taken) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_item <= pending_items[0];
      end else begin
        in_push <= 1'b0;
        in_item <= issp_pkg::in_item_t'(18'($urandom));
      end
    end
  end

  // Drive the receiver's pop at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compare each popped result against the oldest prediction.
  always @(posedge clk) begin
    issp_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result code=%0d value=%0d last=%0b", $time,
                 out_item.stat_code, out_item.stat_value, out_item.last_of_run);
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (want !== out_item) begin
          $display("%0t: mismatch expected code=%0d value=%0d last=%0b", $time,
                   want.stat_code, want.stat_value, want.last_of_run);
          $display("%0t:          actual   code=%0d value=%0d last=%0b", $time,
                   out_item.stat_code, out_item.stat_value, out_item.last_of_run);
          errors++;
        end
        n_checked++;
      end
    end
  end

  // Feed one phase of traffic and drain it.
  task automatic run_phase(int n_items);
    int op_pick, smp, base;
    base = $urandom_range(255) - 128;
    for (int i = 0; i < n_items; i++) begin
      op_pick = $urandom_range(99);
      if (op_pick < 70) begin
        // Repeats and small steps half the time so the run and delta
        // statistics get exercised, full-range samples the other half.
        case ($urandom_range(3))
          0: smp = base;
          1: smp = base + $urandom_range(2) - 1;
          default: smp = $urandom_range(255) - 128;
        endcase
        if (smp > 127) smp = 127;
        if (smp < -128) smp = -128;
        base = smp;
        pending_items.push_back(make_item(issp_pkg::OP_ADD, smp, $urandom_range(255)));
      end else if (op_pick < 85) begin
        pending_items.push_back(make_item(issp_pkg::OP_BIN, $urandom_range(255),
                                          (base + $urandom_range(2) - 1) & 8'hff));
      end else if (op_pick < 97) begin
        pending_items.push_back(make_item(issp_pkg::OP_REPORT, $urandom_range(255),
                                          $urandom_range(255)));
      end else begin
        pending_items.push_back(make_item(issp_pkg::OP_CLEAR, $urandom_range(255),
                                          $urandom_range(255)));
      end
    end
    wait (pending_items.size() == 0 && !in_push);
    wait (expected_stats.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int dir_smp [12];
    dir_smp = '{-128, 127, 0, 0, 0, 1, -1, 127, -128, 85, -86, 5};
    clear_profile();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-stream report, extremes, runs, every operation, clear.
    pending_items.push_back(make_item(issp_pkg::OP_REPORT, 0, 0));
    pending_items.push_back(make_item(issp_pkg::OP_BIN, 0, 255));
    foreach (dir_smp[i]) pending_items.push_back(make_item(issp_pkg::OP_ADD, dir_smp[i], 0));
    pending_items.push_back(make_item(issp_pkg::OP_BIN, 0, 8'h80));
    pending_items.push_back(make_item(issp_pkg::OP_BIN, 0, 0));
    pending_items.push_back(make_item(issp_pkg::OP_BIN, 0, 8'h7f));
    pending_items.push_back(make_item(issp_pkg::OP_REPORT, 0, 0));
    pending_items.push_back(make_item(issp_pkg::OP_CLEAR, 8'hff, 8'hff));
    pending_items.push_back(make_item(issp_pkg::OP_REPORT, 0, 0));
    pending_items.push_back(make_item(issp_pkg::OP_ADD, -7, 0));
    pending_items.push_back(make_item(issp_pkg::OP_REPORT, 0, 0));
    run_phase(0);

    run_phase(53);
    send_idle_pct = 67;
    recv_idle_pct = 22;
    run_phase(53);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(53);

    $display("Sent %0d transactions and checked %0d statistics results", n_sent,
             n_checked);
    $display("across three idling mixes, covering adds, bin reads, reports, clears.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule

/* filelist.f */
rtl/issp_pkg.sv
rtl/issp_ram.sv
rtl/issp_front.sv
rtl/issp_back.sv
rtl/int8_stream_statistics_profiler_top.sv
bench/int8_stream_statistics_profiler_top_test.sv
